### rtl/rtr_pkg.sv
// Package of types and constants for the reliable transfer receiver.
`timescale 1ns / 1ps
package rtr_pkg;
   localparam int CONNECTIONS_DEFAULT = 8;
   localparam int WINDOW_DEFAULT      = 16;

   localparam logic [1:0] KIND_RELEASE = 2'd0;
   localparam logic [1:0] KIND_ACK     = 2'd1;
   localparam logic [1:0] KIND_REFUSED = 2'd2;

   localparam logic CMD_OPEN = 1'b0;
   localparam logic CMD_DATA = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [2:0]  connection;
      logic [31:0] seq_number;
      logic [31:0] total_packets;
      logic [15:0] payload_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  slot_id;
      logic [31:0] ack_seq;
      logic [15:0] released_tag;
      logic        finished;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_CLEAR,
      ST_OPEN_ACK,
      ST_DATA,
      ST_HOLD_RD,
      ST_HOLD_WAIT,
      ST_DRAIN_RD,
      ST_DRAIN_WAIT,
      ST_DRAIN_CHK,
      ST_FINAL
   } state_type;
endpackage

### rtl/rtr_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module rtr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read at one address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/reliable_transfer_receiver_unit.sv
// Top level of the reliable transfer receiver.
`timescale 1ns / 1ps
// An open takes a slot found by a round-robin search of one slot a cycle, then
// a clearing pass over the slot's held marks, then two results. A data item
// drains each held payload through the registered read of the tag memory.
// Results come one a cycle at most, each for one cycle only; the receiver
// cannot stall them, so the user must take every strobe. busy stays high
// until the item's last result has gone.
module reliable_transfer_receiver_unit #(
   parameter int CONNECTIONS = rtr_pkg::CONNECTIONS_DEFAULT,
   parameter int WINDOW      = rtr_pkg::WINDOW_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rtr_pkg::req_type req_data,
   output logic             rsp_strobe,
   output rtr_pkg::rsp_type rsp_data
);
   localparam int SW    = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
   localparam int WW    = $clog2(WINDOW);
   localparam int DEPTH = CONNECTIONS * WINDOW;
   localparam int HW    = $clog2(DEPTH);

   rtr_pkg::state_type state_ff, state_in;
   rtr_pkg::req_type   req_ff, req_in;
   logic [CONNECTIONS-1:0] busy_ff, busy_in;
   logic [DEPTH-1:0]       valid_ff, valid_in;
   logic [SW-1:0]     ptr_ff, ptr_in, slot_ff, slot_in;
   logic [SW:0]       tries_ff, tries_in;
   logic [WW:0]       clr_ff, clr_in;
   logic [31:0]       cnt_ff, cnt_in, lastseq_ff, lastseq_in;
   logic [31:0]       delivered_ff [CONNECTIONS];
   logic [31:0]       total_ff [CONNECTIONS];
   logic              wr_cnt, wr_total;
   logic [31:0]       wr_cnt_val;
   logic              ram_we;
   logic [HW-1:0]     ram_addr;
   logic [15:0]       ram_rd;
   rtr_pkg::rsp_type  rsp_ff, rsp_in;
   logic              strobe_ff, strobe_in;
   logic [32:0]       seq_x, cnt_x;
   logic [WW-1:0]     seq_mod;
   logic [HW-1:0]     held_addr, drain_addr;
   logic [31:0]       next_c;

   rtr_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_tag_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(req_ff.payload_tag),
      .rd_data(ram_rd)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rtr_pkg::ST_IDLE;
         busy_ff   <= '0;
         valid_ff  <= '0;
         ptr_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         busy_ff   <= busy_in;
         valid_ff  <= valid_in;
         ptr_ff    <= ptr_in;
         strobe_ff <= strobe_in;
      end
   end

   // Working and per-slot registers.
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      slot_ff    <= slot_in;
      tries_ff   <= tries_in;
      clr_ff     <= clr_in;
      cnt_ff     <= cnt_in;
      lastseq_ff <= lastseq_in;
      rsp_ff     <= rsp_in;
      if (wr_cnt) begin
         delivered_ff[slot_ff] <= wr_cnt_val;
      end
      if (wr_total) begin
         total_ff[slot_ff] <= req_ff.total_packets;
      end
   end

   // Shared index arithmetic.
   assign seq_x      = {1'b0, req_ff.seq_number};
   assign cnt_x      = {1'b0, cnt_ff};
   assign next_c     = cnt_ff + 32'd1;
   assign seq_mod    = WW'(req_ff.seq_number % WINDOW);
   assign held_addr  = HW'(slot_ff * WINDOW + seq_mod);
   assign drain_addr = HW'(slot_ff * WINDOW + WW'(next_c % WINDOW));

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      busy_in    = busy_ff;
      valid_in   = valid_ff;
      ptr_in     = ptr_ff;
      slot_in    = slot_ff;
      tries_in   = tries_ff;
      clr_in     = clr_ff;
      cnt_in     = cnt_ff;
      lastseq_in = lastseq_ff;
      rsp_in     = rsp_ff;
      strobe_in  = 1'b0;
      wr_cnt     = 1'b0;
      wr_cnt_val = cnt_ff;
      wr_total   = 1'b0;
      ram_we     = 1'b0;
      ram_addr   = held_addr;
      case (state_ff)
         rtr_pkg::ST_IDLE: begin
            if (start && !busy) begin
               req_in   = req_data;
               slot_in  = ptr_ff;
               tries_in = '0;
               if (req_data.cmd == rtr_pkg::CMD_OPEN) begin
                  state_in = rtr_pkg::ST_SEARCH;
               end else if (32'(req_data.connection) < CONNECTIONS) begin
                  slot_in  = SW'(req_data.connection);
                  state_in = rtr_pkg::ST_DATA;
               end
            end
         end
         rtr_pkg::ST_SEARCH: begin
            if (tries_ff == (SW+1)'(CONNECTIONS)) begin
               rsp_in    = '{kind: rtr_pkg::KIND_REFUSED, last: 1'b1, default: '0};
               strobe_in = 1'b1;
               state_in  = rtr_pkg::ST_IDLE;
            end else if (!busy_ff[slot_ff]) begin
               ptr_in   = slot_ff;
               clr_in   = '0;
               state_in = rtr_pkg::ST_CLEAR;
            end else begin
               tries_in = tries_ff + 1'b1;
               slot_in  = (32'(slot_ff) == CONNECTIONS - 1) ? '0 : slot_ff + 1'b1;
            end
         end
         rtr_pkg::ST_CLEAR: begin
            if (clr_ff == (WW+1)'(WINDOW)) begin
               wr_cnt     = 1'b1;
               wr_cnt_val = '0;
               wr_total   = 1'b1;
               rsp_in     = '{kind: rtr_pkg::KIND_RELEASE, slot_id: 3'(slot_ff),
                              ack_seq: '0, released_tag: req_ff.payload_tag,
                              finished: 1'b0, last: 1'b0};
               strobe_in  = 1'b1;
               state_in   = rtr_pkg::ST_OPEN_ACK;
            end else begin
               valid_in[32'(slot_ff) * WINDOW + 32'(clr_ff[WW-1:0])] = 1'b0;
               clr_in = clr_ff + 1'b1;
            end
         end
         rtr_pkg::ST_OPEN_ACK: begin
            busy_in[slot_ff] = (req_ff.total_packets > 32'd1);
            rsp_in    = '{kind: rtr_pkg::KIND_ACK, slot_id: 3'(slot_ff), ack_seq: '0,
                          released_tag: '0, finished: (req_ff.total_packets <= 32'd1),
                          last: 1'b1};
            strobe_in = 1'b1;
            state_in  = rtr_pkg::ST_IDLE;
         end
         rtr_pkg::ST_DATA: begin
            if (!busy_ff[slot_ff]) begin
               state_in = rtr_pkg::ST_IDLE;
            end else begin
               cnt_in     = delivered_ff[slot_ff];
               lastseq_in = total_ff[slot_ff] - 32'd1;
               state_in   = rtr_pkg::ST_HOLD_RD;
            end
         end
         rtr_pkg::ST_HOLD_RD: begin
            // Classify the sequence against the delivered count.
            state_in = rtr_pkg::ST_FINAL;
            if (seq_x == cnt_x + 33'd1 && req_ff.seq_number <= lastseq_ff) begin
               rsp_in    = '{kind: rtr_pkg::KIND_RELEASE, slot_id: 3'(slot_ff),
                             ack_seq: req_ff.seq_number,
                             released_tag: req_ff.payload_tag,
                             finished: 1'b0, last: 1'b0};
               strobe_in = 1'b1;
               cnt_in    = req_ff.seq_number;
               state_in  = rtr_pkg::ST_DRAIN_CHK;
            end else if (seq_x > cnt_x + 33'd1 && seq_x <= cnt_x + 33'(WINDOW)
                         && req_ff.seq_number <= lastseq_ff) begin
               if (!valid_ff[held_addr]) begin
                  valid_in[held_addr] = 1'b1;
                  ram_we = 1'b1;
               end
            end
         end
         rtr_pkg::ST_DRAIN_CHK: begin
            ram_addr = drain_addr;
            if (cnt_ff < lastseq_ff && valid_ff[drain_addr]) begin
               valid_in[drain_addr] = 1'b0;
               state_in = rtr_pkg::ST_DRAIN_WAIT;
            end else begin
               state_in = rtr_pkg::ST_FINAL;
            end
         end
         rtr_pkg::ST_DRAIN_WAIT: begin
            ram_addr  = drain_addr;
            rsp_in    = '{kind: rtr_pkg::KIND_RELEASE, slot_id: 3'(slot_ff),
                          ack_seq: next_c, released_tag: ram_rd,
                          finished: 1'b0, last: 1'b0};
            strobe_in = 1'b1;
            cnt_in    = next_c;
            state_in  = rtr_pkg::ST_DRAIN_CHK;
         end
         rtr_pkg::ST_FINAL: begin
            wr_cnt     = 1'b1;
            wr_cnt_val = cnt_ff;
            if (cnt_ff == lastseq_ff) begin
               busy_in[slot_ff] = 1'b0;
            end
            rsp_in    = '{kind: rtr_pkg::KIND_ACK, slot_id: 3'(slot_ff), ack_seq: cnt_ff,
                          released_tag: '0, finished: (cnt_ff == lastseq_ff),
                          last: 1'b1};
            strobe_in = 1'b1;
            state_in  = rtr_pkg::ST_IDLE;
         end
         default: begin
            state_in = rtr_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != rtr_pkg::ST_IDLE) || strobe_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;
endmodule

### rtl/rtr_checker.sv
// Port-level assertions for the reliable transfer receiver, with their bind.
`timescale 1ns / 1ps
module rtr_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input rtr_pkg::rsp_type rsp_data
);
   // A result is only shown while the block is busy.
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("result outside busy");

   // An accepted request makes the block busy next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accept not followed by busy");

   // Leaving busy happens just after a final result.
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      ($past(rsp_strobe) && !rsp_strobe && !busy) |-> $past(rsp_data.last))
      else $error("busy fell without final result");

   // Acknowledgements carry no tag; releases are never finished.
   a_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_data.kind == rtr_pkg::KIND_ACK && rsp_data.released_tag == '0)
                   || (rsp_data.kind == rtr_pkg::KIND_RELEASE && !rsp_data.finished
                       && !rsp_data.last)
                   || (rsp_data.kind == rtr_pkg::KIND_REFUSED && rsp_data.last)))
      else $error("bad result fields");
endmodule

bind reliable_transfer_receiver_unit rtr_checker u_rtr_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_strobe(rsp_strobe),
   .rsp_data  (rsp_data)
);

### bench/rtr_flow_checker.sv
// Scoreboard that predicts and checks the results of the reliable transfer receiver.
`timescale 1ns / 1ps
module rtr_flow_checker #(
   parameter int CONNECTIONS = rtr_pkg::CONNECTIONS_DEFAULT,
   parameter int WINDOW      = rtr_pkg::WINDOW_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  rtr_pkg::req_type req_data,
   input  logic             rsp_strobe,
   input  rtr_pkg::rsp_type rsp_data,
   output int               failures,
   output int               pending
);
   // Shadow copy of the receiver's connection state.
   logic        slot_open [CONNECTIONS];
   logic [2:0]  next_slot;
   logic [31:0] in_order_count [CONNECTIONS];
   logic [31:0] transfer_total [CONNECTIONS];
   logic        held_mark [CONNECTIONS*WINDOW];
   logic [15:0] held_handle [CONNECTIONS*WINDOW];

   rtr_pkg::rsp_type awaited_rsp [$];

   assign pending = awaited_rsp.size();

   function automatic void push_rsp(logic [1:0] kind, logic [2:0] slot, logic [31:0] seq,
                                    logic [15:0] tag, logic fin, logic lst);
      rtr_pkg::rsp_type r;
      r.kind         = kind;
      r.slot_id      = slot;
      r.ack_seq      = seq;
      r.released_tag = tag;
      r.finished     = fin;
      r.last         = lst;
      awaited_rsp.push_back(r);
   endfunction

   function automatic int held_slot_index(int conn, logic [32:0] seq);
      return conn * WINDOW + int'(seq % WINDOW);
   endfunction

   // Works out every result that one accepted request causes.
   function automatic void predict_request(rtr_pkg::req_type r);
      int          s;
      int          i;
      int          h;
      logic        found;
      logic [32:0] c;
      logic [32:0] last_seq;
      logic [32:0] seq;
      if (r.cmd == rtr_pkg::CMD_OPEN) begin
         s = int'(next_slot);
         found = 1'b0;
         for (i = 0; i < CONNECTIONS; i++) begin
            if (!found) begin
               if (!slot_open[s]) found = 1'b1;
               else s = (s + 1) % CONNECTIONS;
            end
         end
         if (!found) begin
            push_rsp(rtr_pkg::KIND_REFUSED, 3'd0, 32'd0, 16'd0, 1'b0, 1'b1);
            return;
         end
         next_slot = s[2:0];
         for (i = 0; i < WINDOW; i++) held_mark[s*WINDOW + i] = 1'b0;
         in_order_count[s] = 32'd0;
         transfer_total[s] = r.total_packets;
         push_rsp(rtr_pkg::KIND_RELEASE, s[2:0], 32'd0, r.payload_tag, 1'b0, 1'b0);
         // A transfer of at most one packet completes on the open itself.
         slot_open[s] = (r.total_packets > 32'd1);
         push_rsp(rtr_pkg::KIND_ACK, s[2:0], 32'd0, 16'd0, !slot_open[s], 1'b1);
         return;
      end
      s = int'(r.connection);
      if (s >= CONNECTIONS || !slot_open[s]) return;
      c        = {1'b0, in_order_count[s]};
      last_seq = {1'b0, transfer_total[s]} - 33'd1;
      seq      = {1'b0, r.seq_number};
      if (seq == c + 33'd1 && seq <= last_seq) begin
         // In-order packet: release it and drain the held run behind it.
         push_rsp(rtr_pkg::KIND_RELEASE, s[2:0], seq[31:0], r.payload_tag, 1'b0, 1'b0);
         c = seq;
         while (c < last_seq && held_mark[held_slot_index(s, c + 33'd1)]) begin
            h = held_slot_index(s, c + 33'd1);
            held_mark[h] = 1'b0;
            c = c + 33'd1;
            push_rsp(rtr_pkg::KIND_RELEASE, s[2:0], c[31:0], held_handle[h], 1'b0, 1'b0);
         end
         in_order_count[s] = c[31:0];
      end else if (seq > c + 33'd1 && seq <= c + WINDOW && seq <= last_seq) begin
         // Early packet inside the window: the first tag held is kept.
         h = held_slot_index(s, seq);
         if (!held_mark[h]) begin
            held_mark[h]   = 1'b1;
            held_handle[h] = r.payload_tag;
         end
      end
      if (c == last_seq) slot_open[s] = 1'b0;
      push_rsp(rtr_pkg::KIND_ACK, s[2:0], c[31:0], 16'd0, c == last_seq, 1'b1);
   endfunction

   // Requests and results are sampled at the rising edge.
   always @(posedge clock) begin
      rtr_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < CONNECTIONS; i++) slot_open[i] = 1'b0;
         for (int i = 0; i < CONNECTIONS*WINDOW; i++) held_mark[i] = 1'b0;
         next_slot = 3'd0;
         failures  = 0;
         awaited_rsp.delete();
      end else begin
         if (rsp_strobe) begin
            if (awaited_rsp.size() == 0) begin
               failures = failures + 1;
               $display("%0t: unexpected result, expected none, actual %h",
                        $time, rsp_data);
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_data.kind !== want.kind || rsp_data.slot_id !== want.slot_id ||
                   rsp_data.ack_seq !== want.ack_seq ||
                   rsp_data.released_tag !== want.released_tag ||
                   rsp_data.finished !== want.finished || rsp_data.last !== want.last) begin
                  failures = failures + 1;
                  $display({"%0t: result mismatch, expected kind %0d slot %0d seq %h",
                            " tag %h fin %b last %b, actual kind %0d slot %0d seq %h",
                            " tag %h fin %b last %b"},
                           $time, want.kind, want.slot_id, want.ack_seq, want.released_tag,
                           want.finished, want.last, rsp_data.kind, rsp_data.slot_id,
                           rsp_data.ack_seq, rsp_data.released_tag, rsp_data.finished,
                           rsp_data.last);
               end
            end
         end
         if (start && !busy) predict_request(req_data);
      end
   end
endmodule

### bench/tb_reliable_transfer_receiver_unit.sv
// Top of the reliable transfer receiver testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_reliable_transfer_receiver_unit;
   localparam int CYCLE_LIMIT = 200000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic             rsp_strobe;
   rtr_pkg::req_type req_data = '0;
   rtr_pkg::rsp_type rsp_data;
   int               failures;
   int               pending;
   int               cycle_count = 0;
   logic             burst_mode = 1'b0;

   always #6 clock = ~clock;

   reliable_transfer_receiver_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   rtr_flow_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .failures(failures), .pending(pending)
   );

   // Guard against a hung block.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Presents one request until it is taken, then idles for a random gap, or none in burst mode.
   task automatic send_request(logic cmd, logic [2:0] conn, logic [31:0] seq,
                               logic [31:0] total, logic [15:0] tag);
      int gap;
      start    <= 1'b1;
      req_data <= '{cmd: cmd, connection: conn, seq_number: seq,
                    total_packets: total, payload_tag: tag};
      do @(posedge clock); while (busy);
      @(negedge clock);
      gap = burst_mode ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic open_request(logic [31:0] total, logic [15:0] tag);
      send_request(rtr_pkg::CMD_OPEN, 3'($urandom), $urandom, total, tag);
   endtask

   task automatic data_request(logic [2:0] conn, logic [31:0] seq, logic [15:0] tag);
      send_request(rtr_pkg::CMD_DATA, conn, seq, $urandom, tag);
   endtask

   initial begin
      int          pick;
      int          guard;
      logic [31:0] total;
      logic [31:0] seq;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Transfers of zero or one packet complete on the open.
      open_request(32'd0, 16'hFFFF);
      open_request(32'd1, 16'h0000);
      // Fill every slot, then one open more is refused.
      for (int i = 0; i < 8; i++) open_request(32'd2, 16'(i));
      open_request(32'd2, 16'h1234);
      // Stale, far-off and past-the-end sequences are only acknowledged.
      data_request(3'd3, 32'hFFFF_FFFF, 16'hAAAA);
      data_request(3'd3, 32'd5, 16'h5555);
      data_request(3'd3, 32'd0, 16'h0F0F);
      for (int i = 0; i < 8; i++) data_request(3'(i), 32'd1, 16'(16'h8000 + i));
      // Data to an idle slot is ignored.
      data_request(3'd0, 32'd1, 16'h0001);
      // Window behaviour: held, duplicate, window edge, beyond it, then a drain.
      open_request(32'd40, 16'h4000);
      data_request(3'd7, 32'd3, 16'h0333);
      data_request(3'd7, 32'd3, 16'hDEAD);
      data_request(3'd7, 32'd16, 16'h0016);
      data_request(3'd7, 32'd18, 16'h0018);
      data_request(3'd7, 32'd2, 16'h0222);
      data_request(3'd7, 32'd1, 16'h0111);
      open_request(32'hFFFF_FFFF, 16'hFFFF);

      // Random part: mostly short transfers with sequences near the window.
      for (int n = 0; n < 360; n++) begin
         if (n % 40 == 0) burst_mode = ($urandom_range(0, 2) == 0);
         if (n == 180) begin
            start <= 1'b0;
            wait (pending == 0);
            @(negedge clock);
         end
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) total = $urandom_range(2, 24);
            else if (pick < 92) total = $urandom_range(0, 1);
            else total = $urandom;
            open_request(total, 16'($urandom));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 78) seq = $urandom_range(1, 26);
            else if (pick < 88) seq = 32'd0;
            else seq = $urandom;
            data_request(3'($urandom), seq, 16'($urandom));
         end
      end

      start <= 1'b0;
      wait (pending == 0);
      guard = 0;
      while (guard < 80) begin
         @(posedge clock);
         guard++;
      end
      if (failures == 0 && pending == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule

### sim.f
rtl/rtr_pkg.sv
rtl/rtr_ram.sv
rtl/reliable_transfer_receiver_unit.sv
rtl/rtr_checker.sv
bench/rtr_flow_checker.sv
bench/tb_reliable_transfer_receiver_unit.sv
